// ===== rtl/core/cpu_deadline_priority_table_defines.svh =====
// Assertion macros for the deadline priority table.
// Included by the RTL files that carry concurrent checks; needs nothing else.
`ifndef CPU_DEADLINE_PRIORITY_TABLE_DEFINES_SVH
`define CPU_DEADLINE_PRIORITY_TABLE_DEFINES_SVH

// same-cycle implication
`define CDPT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CDPT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/cdpt_pkg.sv =====
// Shared constants for the deadline priority table.
// No dependencies; used by cdpt_rank_unit and the top level.
`default_nettype none

package cdpt_pkg;

   localparam int CPU_W        = 4;
   localparam int DEADLINE_W   = 64;
   localparam int NUM_CPUS_DEF = 16;

endpackage

`default_nettype wire

// ===== rtl/core/cdpt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the slot deadlines and recency ranks.
`default_nettype none

module cdpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/cdpt_rank_unit.sv =====
// Shared rank comparator: decides whether a scanned slot beats the current best.
// Uses cdpt_pkg for the deadline width.
`default_nettype none

module cdpt_rank_unit #(
   parameter int REC_W = 4
) (
   input  wire logic                            order_mode,
   input  wire logic                            best_found,
   input  wire logic [cdpt_pkg::DEADLINE_W-1:0] cand_deadline,
   input  wire logic [cdpt_pkg::DEADLINE_W-1:0] best_deadline,
   input  wire logic [REC_W-1:0]                cand_recency,
   input  wire logic [REC_W-1:0]                best_recency,
   output logic                                 take
);

   import cdpt_pkg::*;

   logic less;
   logic equal;
   logic ahead;

   always_comb begin
      less  = cand_deadline < best_deadline;
      equal = cand_deadline == best_deadline;
      // latest-first ranks strictly greater ahead
      ahead = order_mode ? (~less & ~equal) : less;
      take  = ~best_found | ahead | (equal & (cand_recency < best_recency));
   end

endmodule

`default_nettype wire

// ===== rtl/core/cpu_deadline_priority_table.sv =====
// Top level of the deadline priority table: sequencer, slot state and result register.
// Depends on cdpt_pkg, cdpt_ram, cdpt_rank_unit and the assertion macro header.
//
//  channel | direction | transfer when          | payload
//  req     | in        | req_valid & !req_stall | req_cpu_index, req_deadline, req_insert
//  rsp     | out       | rsp_valid & !rsp_stall | rsp_best_cpu, rsp_best_deadline, rsp_table_empty
//  csr     | in        | csr_wr_en              | csr_wr_data (order mode)
//
// A request transfer is followed by ST_FETCH, then ST_SCAN over every slot through the shared
// rank comparator (one slot per RAM read), then ST_DONE, which loads the result register once
// it is free or being taken; rsp_valid is registered from that load, and the next request can transfer in ST_IDLE.
// req_stall is high from transfer until the result is handed to the output register;
// a result waiting there does not hold off the next request.
// Synchronous active-high reset empties the table and sets earliest-first order.
`default_nettype none

`include "cpu_deadline_priority_table_defines.svh"

module cpu_deadline_priority_table #(
   parameter int NUM_CPUS = cdpt_pkg::NUM_CPUS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic                            csr_wr_data,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [cdpt_pkg::CPU_W-1:0]      req_cpu_index,
   input  wire logic [cdpt_pkg::DEADLINE_W-1:0] req_deadline,
   input  wire logic                            req_insert,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [cdpt_pkg::CPU_W-1:0]      rsp_best_cpu,
   output logic      [cdpt_pkg::DEADLINE_W-1:0] rsp_best_deadline,
   output logic                                 rsp_table_empty
);

   import cdpt_pkg::*;

   localparam int                IDX_W      = $clog2(NUM_CPUS);
   localparam int                REC_W      = IDX_W;
   localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(NUM_CPUS - 1);
   localparam logic [8:0]        NUM_CPUS_9 = 9'(NUM_CPUS);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FETCH = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic                  order_mode_ff, order_mode_in;
   logic [NUM_CPUS-1:0]   present_ff, present_in;
   logic                  found_ff, found_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      cpu_ff, cpu_in;
   logic                  upd_ff, upd_in;
   logic                  ins_ff, ins_in;
   logic                  old_pres_ff, old_pres_in;
   logic [REC_W-1:0]      rec_c_ff, rec_c_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [DEADLINE_W-1:0] best_dl_ff, best_dl_in;
   logic [REC_W-1:0]      best_rec_ff, best_rec_in;
   logic [CPU_W-1:0]      rsp_cpu_ff, rsp_cpu_in;
   logic [DEADLINE_W-1:0] rsp_dl_ff, rsp_dl_in;
   logic                  rsp_empty_ff, rsp_empty_in;

   logic                  req_fire;
   logic [IDX_W-1:0]      req_cpu;
   logic                  req_in_range;
   logic [IDX_W-1:0]      rd_addr;
   logic [DEADLINE_W-1:0] dl_rd;
   logic [REC_W-1:0]      rec_rd;
   logic                  slot_is_c;
   logic                  slot_live;
   logic [REC_W-1:0]      rec_dec;
   logic [REC_W-1:0]      rec_adj;
   logic                  rec_wr_en;
   logic                  dl_wr_en;
   logic                  take;
   logic                  rsp_load;

   assign req_stall    = ~(state_ff == ST_IDLE);
   assign req_fire     = req_valid & ~req_stall;
   assign req_cpu      = IDX_W'(req_cpu_index);
   assign req_in_range = 9'(req_cpu_index) < NUM_CPUS_9;

   // scanned slot, data from the RAMs belongs to idx_ff
   assign slot_is_c = upd_ff & (idx_ff == cpu_ff);
   assign slot_live = present_ff[idx_ff];
   assign rec_dec   = (old_pres_ff && (rec_rd > rec_c_ff)) ? rec_rd - REC_W'(1) : rec_rd;
   assign rec_adj   = slot_is_c ? '0 : rec_dec + REC_W'(ins_ff);
   assign rec_wr_en = (state_ff == ST_SCAN) & slot_live;
   assign dl_wr_en  = req_fire & req_in_range & req_insert;

   always_comb begin
      case (state_ff)
         ST_IDLE:  rd_addr = req_cpu;
         ST_FETCH: rd_addr = '0;
         default:  rd_addr = idx_ff + IDX_W'(1);
      endcase
   end

   cdpt_ram #(
      .WIDTH (DEADLINE_W),
      .DEPTH (NUM_CPUS)
   ) u_dl_ram (
      .clock   (clock),
      .wr_en   (dl_wr_en),
      .wr_addr (req_cpu),
      .wr_data (req_deadline),
      .rd_addr (rd_addr),
      .rd_data (dl_rd)
   );

   cdpt_ram #(
      .WIDTH (REC_W),
      .DEPTH (NUM_CPUS)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (idx_ff),
      .wr_data (rec_adj),
      .rd_addr (rd_addr),
      .rd_data (rec_rd)
   );

   cdpt_rank_unit #(
      .REC_W (REC_W)
   ) u_rank (
      .order_mode    (order_mode_ff),
      .best_found    (found_ff),
      .cand_deadline (dl_rd),
      .best_deadline (best_dl_ff),
      .cand_recency  (rec_adj),
      .best_recency  (best_rec_ff),
      .take          (take)
   );

   assign rsp_load = (state_ff == ST_DONE) & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      state_in      = state_ff;
      order_mode_in = csr_wr_en ? csr_wr_data : order_mode_ff;
      present_in    = present_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_load | (rsp_valid_ff & rsp_stall);
      idx_in        = idx_ff;
      cpu_in        = cpu_ff;
      upd_in        = upd_ff;
      ins_in        = ins_ff;
      old_pres_in   = old_pres_ff;
      rec_c_in      = rec_c_ff;
      best_idx_in   = best_idx_ff;
      best_dl_in    = best_dl_ff;
      best_rec_in   = best_rec_ff;
      rsp_cpu_in    = rsp_cpu_ff;
      rsp_dl_in     = rsp_dl_ff;
      rsp_empty_in  = rsp_empty_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cpu_in      = req_cpu;
               upd_in      = req_in_range;
               ins_in      = req_in_range & req_insert;
               old_pres_in = req_in_range & present_ff[req_cpu];
               if (req_in_range) begin
                  present_in[req_cpu] = req_insert;
               end
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            // recency of the updated slot, read on the transfer cycle
            rec_c_in = rec_rd;
            found_in = 1'b0;
            idx_in   = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (slot_live && take) begin
               found_in    = 1'b1;
               best_idx_in = idx_ff;
               best_dl_in  = dl_rd;
               best_rec_in = rec_adj;
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_cpu_in   = found_ff ? CPU_W'(best_idx_ff) : '0;
               rsp_dl_in    = found_ff ? best_dl_ff : '0;
               rsp_empty_in = ~found_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         order_mode_ff <= 1'b0;
         present_ff    <= '0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         order_mode_ff <= order_mode_in;
         present_ff    <= present_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      cpu_ff       <= cpu_in;
      upd_ff       <= upd_in;
      ins_ff       <= ins_in;
      old_pres_ff  <= old_pres_in;
      rec_c_ff     <= rec_c_in;
      best_idx_ff  <= best_idx_in;
      best_dl_ff   <= best_dl_in;
      best_rec_ff  <= best_rec_in;
      rsp_cpu_ff   <= rsp_cpu_in;
      rsp_dl_ff    <= rsp_dl_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_cpu      = rsp_cpu_ff;
   assign rsp_best_deadline = rsp_dl_ff;
   assign rsp_table_empty   = rsp_empty_ff;

   `CDPT_ASSERT_NXT(a_fire_starts_fetch, clock, reset, req_fire, state_ff == ST_FETCH, "transfer did not start a pass")
   `CDPT_ASSERT_NXT(a_done_loads_rsp, clock, reset, rsp_load, rsp_valid_ff && (state_ff == ST_IDLE), "result not loaded")
   `CDPT_ASSERT_IMP(a_empty_consistent, clock, reset, state_ff == ST_DONE, found_ff == (present_ff != '0), "scan missed a live slot")
   `CDPT_ASSERT_NXT(a_scan_runs_on, clock, reset, (state_ff == ST_SCAN) && (idx_ff != LAST_IDX), (state_ff == ST_SCAN) && (idx_ff == $past(idx_ff) + IDX_W'(1)), "scan cut short")

endmodule

`default_nettype wire
